// ===== src/filtered_event_trace_ring_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the event trace ring
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FILTERED_EVENT_TRACE_RING_ASSERT_SVH
`define FILTERED_EVENT_TRACE_RING_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every edge outside reset
`define FETR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define FETR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FETR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FETR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/fetr_pkg.sv =====
// ----------------------------------------------------------------------------
// Event trace ring package
// Sizes, operation and status codes, and the request/result types.
// ----------------------------------------------------------------------------
package fetr_pkg;

  // ring geometry
  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // per-type counters
  localparam int KIND_COUNT = 32;
  localparam int KIND_AW    = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;

  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // operation codes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] STS_DONE     = 2'd0;
  localparam logic [1:0] STS_DISABLED = 2'd1;
  localparam logic [1:0] STS_FILTERED = 2'd2;
  localparam logic [1:0] STS_RANGE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK    = 1'd1;

  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [RING_AW:0]   ring_sum_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  event_type;
    logic [31:0] time_stamp;
    logic        ident_valid;
    logic [63:0] long_address;
    logic [15:0] net_address;
    logic [47:0] mac_address;
    logic [5:0]  read_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_stamp;
    logic [5:0]  entry_kind;
    logic        entry_ident_valid;
    logic [63:0] entry_long_address;
    logic [15:0] entry_net_address;
    logic [47:0] entry_mac;
    logic [6:0]  stored_count;
    logic [31:0] total_recorded;
    logic [31:0] filtered_total;
    logic [31:0] overwrite_total;
    logic [31:0] kind_total;
  } out_item_t;

  // one stored trace entry
  typedef struct packed {
    logic [31:0] stamp;
    logic [5:0]  kind;
    logic        ident_valid;
    logic [63:0] long_address;
    logic [15:0] net_address;
    logic [47:0] mac;
  } ring_entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } fetr_cmd_t;

endpackage

// ===== src/fetr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Event trace ring controller
// Sequences each request through capture, execute and result hand-off.
// ----------------------------------------------------------------------------
`include "filtered_event_trace_ring_assert.svh"

module fetr_ctrl
  import fetr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output fetr_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_take;
  logic       out_take;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // step the sequence and issue commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_take;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FETR_ASSERT(a_exec_after_take, clk, rst_n, (state_r == S_EXEC) |-> $past(in_take), "execute without an accepted request")
  `FETR_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result raised outside hand-off")
  `FETR_ASSERT(a_done_waits_slot, clk, rst_n, (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE), "result overwritten while stalled")

endmodule

// ===== src/fetr_dpath.sv =====
// ----------------------------------------------------------------------------
// Event trace ring datapath
// Request register, entry ring memory, statistics counters and result register.
// ----------------------------------------------------------------------------
`include "filtered_event_trace_ring_assert.svh"

module fetr_dpath
  import fetr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fetr_cmd_t  cmd,
  input  logic       trace_en,
  input  logic [31:0] type_mask,
  input  in_item_t   in_item,
  output out_item_t  out_item
);

  in_item_t    item_r;
  out_item_t   out_r;
  ring_entry_t ring_mem [RING_DEPTH];
  ring_entry_t rd_data_r;
  ring_entry_t wr_entry;
  logic [1:0]  status_r, status_nxt;
  logic        rd_ok_r, rd_ok_nxt;

  ring_addr_t  wp_r, wp_nxt;
  fill_t       fill_r, fill_nxt;
  cnt_t        rec_cnt_r, rec_cnt_nxt;
  cnt_t        rej_cnt_r, rej_cnt_nxt;
  cnt_t        ovw_cnt_r, ovw_cnt_nxt;
  cnt_t        kind_cnt_r [KIND_COUNT];

  logic        kind_ok;
  logic        ring_full;
  logic        is_record, is_read, is_clear;
  logic        rec_go, rej_go, rd_go;
  logic        pos_bad;
  ring_addr_t  rd_start;
  ring_sum_t   rd_sum;
  ring_addr_t  rd_addr;
  logic [KIND_AW-1:0] kind_idx;
  cnt_t        kind_total;

  // capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
  end

  // decode the request
  assign is_record = (item_r.operation == OP_RECORD);
  assign is_read   = (item_r.operation == OP_READ);
  assign is_clear  = (item_r.operation == OP_CLEAR);
  assign kind_idx  = item_r.event_type[KIND_AW-1:0];
  assign kind_ok   = (item_r.event_type < KIND_COUNT) && type_mask[item_r.event_type[4:0]];
  assign ring_full = (fill_r == fill_t'(RING_DEPTH));
  assign pos_bad   = (item_r.read_position >= fill_r);

  assign rec_go = cmd.exec && is_record && trace_en && kind_ok;
  assign rej_go = cmd.exec && is_record && trace_en && !kind_ok;
  assign rd_go  = cmd.exec && is_read && !pos_bad;

  // oldest entry sits at the write pointer once the ring has wrapped
  assign rd_start = ring_full ? wp_r : '0;
  assign rd_sum   = ring_sum_t'(rd_start) + ring_sum_t'(item_r.read_position);
  assign rd_addr  = (rd_sum >= ring_sum_t'(RING_DEPTH)) ?
                    ring_addr_t'(rd_sum - ring_sum_t'(RING_DEPTH)) : ring_addr_t'(rd_sum);

  // result status of this request
  always_comb begin
    status_nxt = STS_DONE;
    rd_ok_nxt  = 1'b0;
    priority if (is_record && !trace_en) begin
      status_nxt = STS_DISABLED;
    end else if (is_record && !kind_ok) begin
      status_nxt = STS_FILTERED;
    end else if (is_read && pos_bad) begin
      status_nxt = STS_RANGE;
    end else if (is_read) begin
      rd_ok_nxt = 1'b1;
    end else begin
      status_nxt = STS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  // ring memory: write on record, registered read on read
  assign wr_entry.stamp        = item_r.time_stamp;
  assign wr_entry.kind         = item_r.event_type;
  assign wr_entry.ident_valid  = item_r.ident_valid;
  assign wr_entry.long_address = item_r.long_address;
  assign wr_entry.net_address  = item_r.net_address;
  assign wr_entry.mac          = item_r.mac_address;

  always_ff @(posedge clk) begin
    if (rec_go) begin
      ring_mem[wp_r] <= wr_entry;
    end
    if (rd_go) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // advance pointer, fill and statistics
  always_comb begin
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    rec_cnt_nxt = rec_cnt_r;
    rej_cnt_nxt = rej_cnt_r;
    ovw_cnt_nxt = ovw_cnt_r;
    priority if (cmd.exec && is_clear) begin
      wp_nxt      = '0;
      fill_nxt    = '0;
      rec_cnt_nxt = '0;
      rej_cnt_nxt = '0;
      ovw_cnt_nxt = '0;
    end else if (rec_go) begin
      wp_nxt      = (wp_r == ring_addr_t'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      rec_cnt_nxt = rec_cnt_r + 1'b1;
      if (ring_full) begin
        ovw_cnt_nxt = ovw_cnt_r + 1'b1;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end else if (rej_go) begin
      rej_cnt_nxt = rej_cnt_r + 1'b1;
    end else begin
      wp_nxt = wp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      fill_r    <= '0;
      rec_cnt_r <= '0;
      rej_cnt_r <= '0;
      ovw_cnt_r <= '0;
    end else begin
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      rec_cnt_r <= rec_cnt_nxt;
      rej_cnt_r <= rej_cnt_nxt;
      ovw_cnt_r <= ovw_cnt_nxt;
    end
  end

  // per-type counters: drop all on clear, bump one on record
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.exec && is_clear)) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        kind_cnt_r[k] <= '0;
      end
    end else if (rec_go) begin
      kind_cnt_r[kind_idx] <= kind_cnt_r[kind_idx] + 1'b1;
    end
  end

  assign kind_total = (item_r.event_type < KIND_COUNT) ? kind_cnt_r[kind_idx] : '0;

  // build the result from the state after the request
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status             <= status_r;
      out_r.entry_stamp        <= rd_ok_r ? rd_data_r.stamp : '0;
      out_r.entry_kind         <= rd_ok_r ? rd_data_r.kind : '0;
      out_r.entry_ident_valid  <= rd_ok_r ? rd_data_r.ident_valid : 1'b0;
      out_r.entry_long_address <= rd_ok_r ? rd_data_r.long_address : '0;
      out_r.entry_net_address  <= rd_ok_r ? rd_data_r.net_address : '0;
      out_r.entry_mac          <= rd_ok_r ? rd_data_r.mac : '0;
      out_r.stored_count       <= 7'(fill_r);
      out_r.total_recorded     <= rec_cnt_r;
      out_r.filtered_total     <= rej_cnt_r;
      out_r.overwrite_total    <= ovw_cnt_r;
      out_r.kind_total         <= kind_total;
    end
  end

  assign out_item = out_r;

  `FETR_ASSERT(a_fill_bounded, clk, rst_n, fill_r <= fill_t'(RING_DEPTH), "fill count above ring depth")
  `FETR_ASSERT(a_wp_tracks_fill, clk, rst_n, !ring_full |-> (fill_t'(wp_r) == fill_r), "write pointer lost track of fill")

endmodule

// ===== src/filtered_event_trace_ring.sv =====
// ----------------------------------------------------------------------------
// Filtered event trace ring
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Each request (record, read by age, clear) returns one result carrying the
// statistics as they stand after it. A request passes through capture,
// execute with the single-port registered ring read or write, and result
// load; the next request is taken only once that result is loaded, and a
// stalled result holds the next request back in its hand-off step. The ring
// is not cleared after reset and needs no sweep: the fill count bounds
// every read. Configuration writes are always taken at once.
module filtered_event_trace_ring
  import fetr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fetr_cmd_t   cmd;
  logic        trace_en_r;
  logic [31:0] type_mask_r;

  assign cfg_ready = 1'b1;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_en_r  <= 1'b1;
      type_mask_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRACE_ENABLE: trace_en_r  <= cfg_data[0];
        REG_TYPE_MASK:    type_mask_r <= cfg_data[31:0];
        default: begin
          trace_en_r <= trace_en_r;
        end
      endcase
    end
  end

  fetr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fetr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .trace_en  (trace_en_r),
    .type_mask (type_mask_r),
    .in_item   (in_item),
    .out_item  (out_item)
  );

endmodule
